// File: rtl/stock_span_monotonic_stack_assert.svh
// assertion macros for the stock span block
`ifndef STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH
`define STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSMS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition must never hold
`define SSMS_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// File: rtl/ssms_pkg.sv
// shared types and constants for the stock span block
package ssms_pkg;

  localparam int PRICE_W     = 32;
  localparam int SPAN_W      = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// File: rtl/ssms_front.sv
// front end: accepts items, tracks the sequence index and tags overflow
module ssms_front #(
  parameter int MAX_LEN = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ssms_pkg::in_item_t                   in_data,
  output logic                                 q_push,
  output logic [ssms_pkg::PRICE_W+1+1+$clog2(MAX_LEN)-1:0] q_wdata,
  input  logic                                 q_full
);

  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             ovf;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign ovf      = (idx_r == IDX_W'(MAX_LEN));
  assign q_wdata  = {in_data.price, in_data.last, ovf, idx_r[POS_W-1:0]};

  always_comb begin
    idx_nxt = idx_r;
    if (q_push) begin
      if (in_data.last) begin
        idx_nxt = '0;
      end else if (!ovf) begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/ssms_queue.sv
// small register queue between the front and back ends
module ssms_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty
);

  localparam int PTR_W = $clog2(ssms_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ssms_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [ssms_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(ssms_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(ssms_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(ssms_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/ssms_back.sv
// back end: monotonic stack engine with stack memory and result register
module ssms_back #(
  parameter int MAX_LEN = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  logic [ssms_pkg::PRICE_W+1+1+$clog2(MAX_LEN)-1:0] q_rdata,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ssms_pkg::out_item_t                  out_data,
  output ssms_pkg::back_status_t               status
);

  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);
  localparam int MEM_W = ssms_pkg::PRICE_W + POS_W;
  localparam int EW    = ssms_pkg::PRICE_W + 2 + POS_W;
  localparam int SW    = (IDX_W > ssms_pkg::SPAN_W) ? IDX_W : ssms_pkg::SPAN_W;
  localparam logic [SW-1:0] SPAN_OVF = SW'(MAX_LEN);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_LOAD} state_t;

  state_t                         state_r;
  logic [IDX_W-1:0]               count_r;
  logic signed [ssms_pkg::PRICE_W-1:0] top_val_r;
  logic [POS_W-1:0]               top_pos_r;
  logic signed [ssms_pkg::PRICE_W-1:0] price_r;
  logic                           last_r;
  logic [POS_W-1:0]               idx_r;
  logic                           out_valid_r;
  ssms_pkg::out_item_t            out_data_r;

  logic [MEM_W-1:0]               mem [MAX_LEN];
  logic [MEM_W-1:0]               rd_data_r;
  logic [POS_W-1:0]               rd_addr;

  logic                           slot_free;
  logic                           pop_top;
  logic                           do_push;
  logic                           out_load;
  logic [SW-1:0]                  span_new;
  logic signed [ssms_pkg::PRICE_W-1:0] e_price;
  logic                           e_last;
  logic                           e_ovf;
  logic [POS_W-1:0]               e_idx;

  assign e_price = q_rdata[EW-1 -: ssms_pkg::PRICE_W];
  assign e_last  = q_rdata[POS_W+1];
  assign e_ovf   = q_rdata[POS_W];
  assign e_idx   = q_rdata[POS_W-1:0];

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == S_IDLE) && q_valid && slot_free;
  assign pop_top   = (count_r != '0) && (top_val_r <= price_r);
  assign do_push   = (state_r == S_CMP) && !pop_top;
  assign out_load  = (q_pop && e_ovf) || do_push;
  assign rd_addr   = count_r[POS_W-1:0] - POS_W'(2);
  assign span_new  = (count_r == '0) ? (SW'(idx_r) + SW'(1)) : (SW'(idx_r) - SW'(top_pos_r));

  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign status.busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[count_r[POS_W-1:0]] <= {price_r, idx_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            price_r <= e_price;
            last_r  <= e_last;
            idx_r   <= e_idx;
            if (e_ovf) begin
              out_data_r.span     <= SPAN_OVF[ssms_pkg::SPAN_W-1:0];
              out_data_r.overflow <= 1'b1;
              if (e_last) begin
                count_r <= '0;
              end
            end else begin
              state_r <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (pop_top) begin
            count_r <= count_r - IDX_W'(1);
            state_r <= S_LOAD;
          end else begin
            top_val_r           <= price_r;
            top_pos_r           <= idx_r;
            count_r             <= last_r ? '0 : count_r + IDX_W'(1);
            out_data_r.span     <= span_new[ssms_pkg::SPAN_W-1:0];
            out_data_r.overflow <= 1'b0;
            state_r             <= S_IDLE;
          end
        end
        S_LOAD: begin
          top_val_r <= rd_data_r[MEM_W-1 -: ssms_pkg::PRICE_W];
          top_pos_r <= rd_data_r[POS_W-1:0];
          state_r   <= S_CMP;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/stock_span_monotonic_stack.sv
// top level of the stock span block: front end, queue and stack engine
//
// Stock span over a stream of signed 32-bit prices, one result per item. An
// item is written into the queue and taken from it once the engine is idle
// and the result register is free. The stack engine compares it with the
// top of the stack and then pushes it and registers its span, or pops the top
// and loads the next top from the registered read of the stack memory before
// comparing again. Each entry is popped at most once. Items beyond MAX_LEN
// in a sequence bypass the compare and return span MAX_LEN with overflow
// set. An item with last set clears the stack and the index after its
// result. The input keeps accepting into a two-entry queue while the engine
// works or the result register is stalled, until the queue is full.
module stock_span_monotonic_stack #(
  parameter int MAX_LEN = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssms_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssms_pkg::out_item_t out_data
);

  `include "stock_span_monotonic_stack_assert.svh"

  localparam int EW = ssms_pkg::PRICE_W + 2 + $clog2(MAX_LEN);
  localparam logic [ssms_pkg::SPAN_W-1:0] OVF_SPAN = ssms_pkg::SPAN_W'(MAX_LEN);

  logic                   q_push;
  logic [EW-1:0]          q_wdata;
  logic                   q_full;
  logic                   q_pop;
  logic [EW-1:0]          q_rdata;
  logic                   q_valid;
  ssms_pkg::back_status_t back_status;

  ssms_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  ssms_queue #(
    .W(EW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_valid)
  );

  ssms_back #(
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .status   (back_status)
  );

  `SSMS_ASSERT_IMPL(a_full_stalls, q_full, in_stall)
  `SSMS_ASSERT_IMPL(a_start_has_item, $rose(back_status.busy), $past(q_valid))
  `SSMS_ASSERT_IMPL(a_ovf_span, out_valid && out_data.overflow, out_data.span == OVF_SPAN)
  `SSMS_ASSERT_NEVER(a_pop_while_busy, q_pop && back_status.busy)

endmodule
